/* design/suffix_automaton_builder_macros.svh */
// Assertion macros for the checker file sab_checker.sv.
`ifndef SUFFIX_AUTOMATON_BUILDER_MACROS_SVH
`define SUFFIX_AUTOMATON_BUILDER_MACROS_SVH

// Implication checked at each clock edge, disabled while reset is held.
`define SAB_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence checked at the clock edge after the antecedent.
`define SAB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/sab_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sab_pkg;
    localparam int MAX_LEN   = 1024;
    localparam int ALPHABET  = 26;
    localparam int NODE_CAP  = 2 * MAX_LEN;
    localparam int NODE_W    = 11;
    localparam int CNT_W     = 12;
    localparam int LEN_W     = 11;
    localparam int SYM_W     = 5;
    localparam int TR_DEPTH  = NODE_CAP * ALPHABET;
    localparam int TR_AW     = $clog2(TR_DEPTH);

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] tgt;
    } t_tr_entry;

    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] wnode;
        logic [SYM_W-1:0]  wsym;
        t_tr_entry         wdata;
        logic [NODE_W-1:0] rnode;
        logic [SYM_W-1:0]  rsym;
    } t_tr_req;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [NODE_W-1:0] link;
    } t_node;
endpackage
`default_nettype wire

/* design/suffix_automaton_builder.sv */
`timescale 1ns / 1ps
// Channel   Direction  Ports                      Word
// s         in         i_s_tvalid/o_s_tready      tuser: req_type; tdata: symbol, node_index
// m         out        o_m_tvalid/i_m_tready      tdata: status, node_total, found,
//                                                        target_node, last_node
// One request is worked at a time; a finished word waits in the output register.
// Lookup reads one transition entry. Clear sweeps the root row of the transition memory.
// Append clears the new state's row, walks the suffix links and may copy a row into a clone.
// After reset a pass clears the root row; no request is accepted meanwhile.
// A stalled output only holds the next request in its final state, S_DONE.
`default_nettype none
module suffix_automaton_builder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // symbol[4:0], node_index[15:5]
    input  wire logic [1:0]  i_s_tuser,   // req_type[1:0]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata    // status[0], node_total[12:1], found[13],
                                          // target_node[24:14], last_node[35:25]
);
    import sab_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_CLR   = 14'b00000000000010,
        S_A_LEN = 14'b00000000000100,
        S_W_RD  = 14'b00000000001000,
        S_W_CHK = 14'b00000000010000,
        S_Q_RD  = 14'b00000000100000,
        S_Q_CHK = 14'b00000001000000,
        S_Q_LQ  = 14'b00000010000000,
        S_Q_LCU = 14'b00000100000000,
        S_COPY  = 14'b00001000000000,
        S_R_RD  = 14'b00010000000000,
        S_R_CHK = 14'b00100000000000,
        S_L_CHK = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } t_state;

    t_state            r_state;
    t_req              r_req;
    logic              r_boot;
    logic [CNT_W-1:0]  r_cnt;
    logic [NODE_W-1:0] r_last;
    logic [LEN_W-1:0]  r_alen;
    logic [SYM_W-1:0]  r_sym;
    logic [SYM_W-1:0]  r_k;
    logic [NODE_W-1:0] r_cnode;
    logic [NODE_W-1:0] r_cur;
    logic [NODE_W-1:0] r_p;
    logic [NODE_W-1:0] r_q;
    logic [NODE_W-1:0] r_cl;
    logic [LEN_W-1:0]  r_curlen;
    logic [LEN_W-1:0]  r_lenp1;
    logic [LEN_W-1:0]  r_lenq;
    logic              r_status;
    logic              r_found;
    logic [NODE_W-1:0] r_target;
    logic              r_ovalid;
    logic [39:0]       r_odata;

    t_node             r_node_mem [NODE_CAP];
    t_node             node_rd;
    logic              nw_en;
    logic [NODE_W-1:0] nw_addr;
    t_node             nw_data;
    logic [NODE_W-1:0] nr_addr;

    t_tr_req           tr_req;
    t_tr_entry         tr_rd;

    logic [SYM_W-1:0]  in_sym;
    logic [NODE_W-1:0] in_node;
    logic              tr_hit_q;

    assign in_sym     = i_s_tdata[4:0];
    assign in_node    = i_s_tdata[15:5];
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign tr_hit_q   = tr_rd.valid && (tr_rd.tgt == r_q);

    sab_trans_mem u_trans (
        .i_clk     (i_clk),
        .i_req     (tr_req),
        .o_rd_data (tr_rd)
    );

    always_ff @(posedge i_clk) begin
        if (nw_en) begin
            r_node_mem[nw_addr] <= nw_data;
        end
        node_rd <= r_node_mem[nr_addr];
    end

    always_comb begin
        case (r_state)
            S_IDLE:  nr_addr = r_last;
            S_Q_RD:  nr_addr = r_q;
            default: nr_addr = r_p;
        endcase
    end

    always_comb begin
        nw_en   = 1'b0;
        nw_addr = r_cur;
        nw_data = '{len: r_curlen, link: '0};
        case (r_state)
            S_CLR: begin
                // Clearing the root also resets its length and link.
                if (r_req != REQ_APPEND && r_k == '0) begin
                    nw_en   = 1'b1;
                    nw_addr = '0;
                    nw_data = '0;
                end
            end
            S_A_LEN: begin
                nw_en   = 1'b1;
                nw_data = '{len: node_rd.len + LEN_W'(1), link: '0};
            end
            S_Q_CHK: begin
                nw_en = 1'b1;
                if (node_rd.len == r_lenp1) begin
                    nw_data = '{len: r_curlen, link: r_q};
                end else begin
                    nw_addr = r_cnt[NODE_W-1:0];
                    nw_data = '{len: r_lenp1, link: node_rd.link};
                end
            end
            S_Q_LQ: begin
                nw_en   = 1'b1;
                nw_addr = r_q;
                nw_data = '{len: r_lenq, link: r_cl};
            end
            S_Q_LCU: begin
                nw_en   = 1'b1;
                nw_data = '{len: r_curlen, link: r_cl};
            end
            default: nw_en = 1'b0;
        endcase
    end

    always_comb begin
        tr_req       = '0;
        tr_req.rnode = r_p;
        tr_req.rsym  = r_sym;
        case (r_state)
            S_IDLE: begin
                tr_req.rnode = in_node;
                tr_req.rsym  = in_sym;
            end
            S_CLR: begin
                tr_req.we    = 1'b1;
                tr_req.wnode = r_cnode;
                tr_req.wsym  = r_k;
            end
            S_W_CHK: begin
                tr_req.we    = !tr_rd.valid;
                tr_req.wnode = r_p;
                tr_req.wsym  = r_sym;
                tr_req.wdata = '{valid: 1'b1, tgt: r_cur};
            end
            S_COPY: begin
                // Read entry k of the source row while writing entry k-1 of the clone.
                tr_req.rnode = r_q;
                tr_req.rsym  = r_k;
                tr_req.we    = (r_k != '0);
                tr_req.wnode = r_cl;
                tr_req.wsym  = r_k - SYM_W'(1);
                tr_req.wdata = tr_rd;
            end
            S_R_CHK: begin
                tr_req.we    = tr_hit_q;
                tr_req.wnode = r_p;
                tr_req.wsym  = r_sym;
                tr_req.wdata = '{valid: 1'b1, tgt: r_cl};
            end
            default: tr_req.we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_req    <= REQ_CLEAR;
            r_boot   <= 1'b1;
            r_cnt    <= CNT_W'(1);
            r_last   <= '0;
            r_alen   <= '0;
            r_k      <= '0;
            r_cnode  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // In S_DONE the output valid is handled by the state itself.
            if (r_ovalid && i_m_tready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_req    <= t_req'(i_s_tuser);
                        r_sym    <= in_sym;
                        r_status <= (t_req'(i_s_tuser) == REQ_APPEND) &&
                                    (r_alen >= LEN_W'(MAX_LEN));
                        r_found  <= 1'b0;
                        r_target <= '0;
                        case (t_req'(i_s_tuser))
                            REQ_APPEND: begin
                                if (r_alen >= LEN_W'(MAX_LEN)) begin
                                    r_state <= S_DONE;
                                end else if (in_sym < SYM_W'(ALPHABET)) begin
                                    r_cur   <= r_cnt[NODE_W-1:0];
                                    r_cnode <= r_cnt[NODE_W-1:0];
                                    r_cnt   <= r_cnt + CNT_W'(1);
                                    r_alen  <= r_alen + LEN_W'(1);
                                    r_p     <= r_last;
                                    r_last  <= r_cnt[NODE_W-1:0];
                                    r_state <= S_A_LEN;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            REQ_LOOKUP: begin
                                if (in_sym < SYM_W'(ALPHABET) && CNT_W'(in_node) < r_cnt) begin
                                    r_state <= S_L_CHK;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            REQ_CLEAR: begin
                                r_cnt   <= CNT_W'(1);
                                r_last  <= '0;
                                r_alen  <= '0;
                                r_cnode <= '0;
                                r_k     <= '0;
                                r_state <= S_CLR;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_A_LEN: begin
                    r_curlen <= node_rd.len + LEN_W'(1);
                    r_k      <= '0;
                    r_state  <= S_CLR;
                end
                S_CLR: begin
                    r_k <= r_k + SYM_W'(1);
                    if (r_k == SYM_W'(ALPHABET - 1)) begin
                        if (r_boot) begin
                            r_boot  <= 1'b0;
                            r_state <= S_IDLE;
                        end else if (r_req == REQ_APPEND) begin
                            r_state <= S_W_RD;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_W_RD: r_state <= S_W_CHK;
                S_W_CHK: begin
                    if (!tr_rd.valid) begin
                        if (r_p == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_p     <= node_rd.link;
                            r_state <= S_W_RD;
                        end
                    end else begin
                        r_q     <= tr_rd.tgt;
                        r_lenp1 <= node_rd.len + LEN_W'(1);
                        r_state <= S_Q_RD;
                    end
                end
                S_Q_RD: r_state <= S_Q_CHK;
                S_Q_CHK: begin
                    r_lenq <= node_rd.len;
                    if (node_rd.len == r_lenp1) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cl    <= r_cnt[NODE_W-1:0];
                        r_cnt   <= r_cnt + CNT_W'(1);
                        r_state <= S_Q_LQ;
                    end
                end
                S_Q_LQ: r_state <= S_Q_LCU;
                S_Q_LCU: begin
                    r_k     <= '0;
                    r_state <= S_COPY;
                end
                S_COPY: begin
                    r_k <= r_k + SYM_W'(1);
                    if (r_k == SYM_W'(ALPHABET)) begin
                        r_state <= S_R_RD;
                    end
                end
                S_R_RD: r_state <= S_R_CHK;
                S_R_CHK: begin
                    if (tr_hit_q && r_p != '0) begin
                        r_p     <= node_rd.link;
                        r_state <= S_R_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_L_CHK: begin
                    r_found  <= tr_rd.valid;
                    r_target <= tr_rd.valid ? tr_rd.tgt : '0;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {4'b0, r_last, r_target, r_found, r_cnt, r_status};
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* design/sab_trans_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
module sab_trans_mem (
    input  wire logic             i_clk,
    input  wire sab_pkg::t_tr_req i_req,
    output sab_pkg::t_tr_entry    o_rd_data
);
    import sab_pkg::*;

    t_tr_entry        r_mem [TR_DEPTH];
    logic [TR_AW-1:0] wr_addr;
    logic [TR_AW-1:0] rd_addr;

    // Row-major layout: one row of ALPHABET entries per state.
    assign wr_addr = TR_AW'(i_req.wnode) * TR_AW'(ALPHABET) + TR_AW'(i_req.wsym);
    assign rd_addr = TR_AW'(i_req.rnode) * TR_AW'(ALPHABET) + TR_AW'(i_req.rsym);

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[wr_addr] <= i_req.wdata;
        end
        o_rd_data <= r_mem[rd_addr];
    end
endmodule
`default_nettype wire

/* design/sab_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "suffix_automaton_builder_macros.svh"
module sab_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [39:0] o_m_tdata
);
    // A word held back by the sink stays offered.
    `SAB_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid, "output word dropped")
    // One request is worked at a time, so acceptance never repeats back to back.
    `SAB_ASSERT_NEXT(a_one_at_a_time, i_s_tvalid && o_s_tready, !o_s_tready, "request overlap")
    // The root always exists.
    `SAB_ASSERT_IMPL(a_total_nonzero, o_m_tvalid, o_m_tdata[12:1] != 12'd0, "zero states")
    // A refused append is never a lookup hit.
    `SAB_ASSERT_IMPL(a_full_not_found, o_m_tvalid, !(o_m_tdata[0] && o_m_tdata[13]),
        "full status with found")
endmodule

bind suffix_automaton_builder sab_checker u_sab_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
`default_nettype wire

/* test/suffix_automaton_builder_tb.sv */
`timescale 1ns / 1ps
module suffix_automaton_builder_tb;
    import sab_pkg::*;

    typedef struct packed {
        logic [10:0] last_node;
        logic [10:0] target_node;
        logic        found;
        logic [11:0] node_total;
        logic        status;
    } t_answer;

    // Behavioral copy of the automaton; predicts one answer per request.
    class automaton_scoreboard;
        logic              edge_ok  [NODE_CAP][ALPHABET];
        logic [NODE_W-1:0] edge_to  [NODE_CAP][ALPHABET];
        logic [NODE_W-1:0] link_of  [NODE_CAP];
        int                depth_of [NODE_CAP];
        int                node_count;
        int                tail_node;
        int                text_len;
        t_answer           pending[$];
        int                mismatches;

        function void wipe_row(int n);
            for (int k = 0; k < ALPHABET; k++) begin
                edge_ok[n][k] = 1'b0;
                edge_to[n][k] = '0;
            end
        endfunction

        function void restart();
            wipe_row(0);
            link_of[0] = '0;
            depth_of[0] = 0;
            node_count = 1;
            tail_node = 0;
            text_len = 0;
        endfunction

        function void extend(int c);
            int cur, p, q, cl;
            bit walking;
            cur = node_count++;
            p = tail_node;
            walking = 1;
            wipe_row(cur);
            depth_of[cur] = depth_of[p] + 1;
            link_of[cur] = '0;
            while (walking && !edge_ok[p][c]) begin
                edge_ok[p][c] = 1'b1;
                edge_to[p][c] = NODE_W'(cur);
                if (p == 0) walking = 0; else p = link_of[p];
            end
            tail_node = cur;
            text_len++;
            if (!walking) return;
            q = edge_to[p][c];
            if (depth_of[q] == depth_of[p] + 1) begin
                link_of[cur] = NODE_W'(q);
            end else begin
                cl = node_count++;
                for (int k = 0; k < ALPHABET; k++) begin
                    edge_ok[cl][k] = edge_ok[q][k];
                    edge_to[cl][k] = edge_to[q][k];
                end
                link_of[cl] = link_of[q];
                depth_of[cl] = depth_of[p] + 1;
                link_of[q] = NODE_W'(cl);
                link_of[cur] = NODE_W'(cl);
                while (walking && edge_ok[p][c] && edge_to[p][c] == q) begin
                    edge_to[p][c] = NODE_W'(cl);
                    if (p == 0) walking = 0; else p = link_of[p];
                end
            end
        endfunction

        function void note_request(logic [1:0] kind, logic [4:0] sym, logic [10:0] node);
            t_answer a;
            a = '0;
            if (kind == REQ_APPEND) begin
                if (text_len >= MAX_LEN) a.status = 1'b1;
                else if (sym < ALPHABET) extend(sym);
            end else if (kind == REQ_LOOKUP) begin
                if (sym < ALPHABET && node < node_count && edge_ok[node][sym]) begin
                    a.found = 1'b1;
                    a.target_node = edge_to[node][sym];
                end
            end else if (kind == REQ_CLEAR) begin
                restart();
            end
            a.node_total = 12'(node_count);
            a.last_node = 11'(tail_node);
            pending.push_back(a);
        endfunction

        function void check_answer(t_answer got);
            t_answer w;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", got);
                return;
            end
            w = pending.pop_front();
            if (got !== w) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("word mismatch: expected st=%0d tot=%0d f=%0d tg=%0d ln=%0d, ",
                           w.status, w.node_total, w.found, w.target_node, w.last_node);
                    $display("got st=%0d tot=%0d f=%0d tg=%0d ln=%0d",
                             got.status, got.node_total, got.found, got.target_node,
                             got.last_node);
                end
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n;
    logic        i_s_tvalid, o_s_tready;
    logic [15:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid, i_m_tready;
    logic [39:0] o_m_tdata;

    automaton_scoreboard board;
    int send_idle_pct, recv_idle_pct;
    bit hold_recv;

    suffix_automaton_builder uut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random back-pressure plus an optional long hold.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) board.check_answer(t_answer'(o_m_tdata[35:0]));
            i_m_tready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // The block is busy after each word, so the closing
    // edge here never costs an accept opportunity.
    task automatic send_request(logic [1:0] kind, logic [4:0] sym, logic [10:0] node);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser <= kind;
        i_s_tdata <= {node, sym};
        do @(posedge i_clk); while (!o_s_tready);
        board.note_request(kind, sym, node);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic random_request(int alpha);
        int r;
        logic [1:0] kind;
        logic [4:0] sym;
        logic [10:0] node;
        r = $urandom_range(999);
        sym = 5'($urandom_range(alpha - 1));
        node = 11'($urandom_range(board.node_count + 2));
        if (r < 3) begin
            kind = REQ_CLEAR;
        end else if (r < 10) begin
            kind = REQ_NONE; sym = 5'($urandom); node = 11'($urandom);
        end else if (r < 20) begin
            kind = 2'($urandom_range(1)); sym = 5'($urandom_range(31, 26));
        end else if (r < 30) begin
            kind = REQ_LOOKUP; node = 11'($urandom);
        end else if (r < 60) begin
            kind = REQ_LOOKUP; sym = 5'($urandom);
        end else if (r < 600) begin
            kind = REQ_APPEND;
        end else begin
            kind = REQ_LOOKUP;
        end
        send_request(kind, sym, node);
    endtask

    initial begin
        string seed_text;
        board = new();
        board.restart();
        board.mismatches = 0;
        hold_recv = 0;
        send_idle_pct = 37;
        recv_idle_pct = 58;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        seed_text = "abbabaab";
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: repeats force clones, then edge cases.
        foreach (seed_text[k]) send_request(REQ_APPEND, 5'(seed_text[k] - "a"), 0);
        send_request(REQ_APPEND, 25, 0);
        send_request(REQ_APPEND, 26, 0);
        send_request(REQ_APPEND, 31, 0);
        send_request(REQ_LOOKUP, 0, 0);
        send_request(REQ_LOOKUP, 25, 0);
        send_request(REQ_LOOKUP, 1, 1);
        send_request(REQ_LOOKUP, 31, 0);
        send_request(REQ_LOOKUP, 0, 11'd2047);
        send_request(REQ_LOOKUP, 2, 5);
        send_request(REQ_NONE, 5'h1f, 11'h7ff);
        send_request(REQ_CLEAR, 0, 0);
        send_request(REQ_LOOKUP, 0, 0);
        send_request(REQ_LOOKUP, 0, 1);
        drain();

        // Fill to the length limit over a small alphabet, then refusals.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (MAX_LEN + 6) send_request(REQ_APPEND, 5'($urandom_range(2)), 0);
        repeat (40) random_request(3);
        drain();

        // Long receiver hold while requests keep coming.
        fork
            begin
                hold_recv = 1;
                repeat (400) @(posedge i_clk);
                hold_recv = 0;
            end
            repeat (6) random_request(26);
        join
        send_request(REQ_CLEAR, 0, 0);

        send_idle_pct = 37; recv_idle_pct = 58;
        repeat (160) random_request($urandom_range(1) ? 2 : 26);
        send_idle_pct = 58; recv_idle_pct = 37;
        repeat (160) random_request($urandom_range(1) ? 4 : 26);
        send_idle_pct = 0; recv_idle_pct = 0;
        repeat (160) random_request(26);

        drain();
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

/* sim.f */
+incdir+design
design/sab_pkg.sv
design/sab_trans_mem.sv
design/suffix_automaton_builder.sv
design/sab_checker.sv
test/suffix_automaton_builder_tb.sv
